// ----- sv/dmxp_pkg.sv -----
`timescale 1ns / 1ps
package dmxp_pkg;

   localparam int NUM_LINES = 4;
   localparam int SLOTS = 512;

   localparam int OFFSET_W = 10;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   // header layout, offsets within the udp payload
   localparam logic [OFFSET_W-1:0] ART_OPCODE_LO = OFFSET_W'(8);
   localparam logic [OFFSET_W-1:0] ART_OPCODE_HI = OFFSET_W'(9);
   localparam logic [OFFSET_W-1:0] ART_UNIV_LO = OFFSET_W'(14);
   localparam logic [OFFSET_W-1:0] ART_UNIV_HI = OFFSET_W'(15);
   localparam logic [OFFSET_W-1:0] ART_DATA_START = OFFSET_W'(18);
   localparam logic [OFFSET_W-1:0] SACN_UNIV_HI = OFFSET_W'(113);
   localparam logic [OFFSET_W-1:0] SACN_UNIV_LO = OFFSET_W'(114);
   localparam logic [OFFSET_W-1:0] SACN_START_CODE = OFFSET_W'(125);
   localparam logic [OFFSET_W-1:0] SACN_DATA_START = OFFSET_W'(126);
   localparam logic [OFFSET_W-1:0] ART_ID_LEN = OFFSET_W'(7);
   localparam logic [OFFSET_W-1:0] SACN_ID_FIRST = OFFSET_W'(4);
   localparam logic [OFFSET_W-1:0] SACN_ID_LAST = OFFSET_W'(7);

   // end of data area, one past the last slot (at most 638, fits 11 bits)
   localparam logic [OFFSET_W:0] ART_DATA_END = OFFSET_W'(18) + (OFFSET_W+1)'(SLOTS);
   localparam logic [OFFSET_W:0] SACN_DATA_END = OFFSET_W'(126) + (OFFSET_W+1)'(SLOTS);

   localparam logic [15:0] ART_OPDMX = 16'h5000;
   localparam logic [15:0] UNIV_LIMIT = 16'(NUM_LINES);
   localparam logic [8:0] LAST_SLOT = 9'(SLOTS - 1);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_packet;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] line;
      logic [8:0] slot;
      logic [7:0] level;
      logic       frame_complete;
   } rsp_payload_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic                lighting_ok;
      logic                stream_ok;
   } dmxp_status_type;

   // "Art-Net" identifier
   function automatic logic [7:0] art_id_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h41;
         3'd1: c = 8'h72;
         3'd2: c = 8'h74;
         3'd3: c = 8'h2D;
         3'd4: c = 8'h4E;
         3'd5: c = 8'h65;
         3'd6: c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "ASC-" identifier
   function automatic logic [7:0] sacn_id_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h41;
         2'd1: c = 8'h53;
         2'd2: c = 8'h43;
         2'd3: c = 8'h2D;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- sv/dmxp_parser.sv -----
`timescale 1ns / 1ps
module dmxp_parser import dmxp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_payload_type byte_in,
   output logic            emit,
   output rsp_payload_type result,
   output dmxp_status_type status
);

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                lighting_ok_ff, lighting_ok_in;
   logic                stream_ok_ff, stream_ok_in;
   logic                extra_ok_ff, extra_ok_in;
   logic [15:0]         universe_ff, universe_in;
   logic [7:0]          opcode_lo_ff, opcode_lo_in;

   logic [7:0]          b;
   logic [15:0]         univ_art;
   logic                art_emit, sacn_emit;
   logic [OFFSET_W-1:0] slot_off;

   always_comb begin
      b = byte_in.payload_byte;

      lighting_ok_in = lighting_ok_ff;
      if (offset_ff < ART_ID_LEN && b != art_id_char(offset_ff[2:0])) begin
         lighting_ok_in = 1'b0;
      end
      if (offset_ff == ART_OPCODE_HI && {b, opcode_lo_ff} != ART_OPDMX) begin
         lighting_ok_in = 1'b0;
      end

      stream_ok_in = stream_ok_ff;
      if (offset_ff >= SACN_ID_FIRST && offset_ff <= SACN_ID_LAST &&
          b != sacn_id_char(offset_ff[1:0])) begin
         stream_ok_in = 1'b0;
      end

      opcode_lo_in = (offset_ff == ART_OPCODE_LO) ? b : opcode_lo_ff;

      // universe is captured only under its own header flag
      univ_art = universe_ff;
      if (lighting_ok_in && offset_ff == ART_UNIV_LO) begin
         univ_art = {universe_ff[15:8], b};
      end else if (lighting_ok_in && offset_ff == ART_UNIV_HI) begin
         univ_art = {b, universe_ff[7:0]};
      end
      universe_in = univ_art;
      extra_ok_in = extra_ok_ff;
      if (stream_ok_in) begin
         if (offset_ff == SACN_UNIV_HI) begin
            universe_in = {b, univ_art[7:0]};
         end else if (offset_ff == SACN_UNIV_LO) begin
            universe_in = {univ_art[15:8], b};
         end else if (offset_ff == SACN_START_CODE && b != 8'h00) begin
            extra_ok_in = 1'b0;
         end
      end

      art_emit = lighting_ok_in && universe_in < UNIV_LIMIT &&
                 offset_ff >= ART_DATA_START &&
                 {1'b0, offset_ff} < ART_DATA_END;
      sacn_emit = stream_ok_in && extra_ok_in && universe_in < UNIV_LIMIT &&
                  offset_ff >= SACN_DATA_START &&
                  {1'b0, offset_ff} < SACN_DATA_END;
      emit = art_emit || sacn_emit;
      slot_off = art_emit ? offset_ff - ART_DATA_START : offset_ff - SACN_DATA_START;

      result.line           = universe_in[1:0];
      result.slot           = slot_off[8:0];
      result.level          = b;
      result.frame_complete = (slot_off[8:0] == LAST_SLOT);

      status.byte_offset = offset_ff;
      status.lighting_ok = lighting_ok_ff;
      status.stream_ok   = stream_ok_ff;

      if (byte_in.end_of_packet) begin
         offset_in = '0;
      end else begin
         offset_in = (offset_ff == OFFSET_MAX) ? OFFSET_MAX : offset_ff + OFFSET_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && byte_in.end_of_packet)) begin
         offset_ff      <= '0;
         lighting_ok_ff <= 1'b1;
         stream_ok_ff   <= 1'b1;
         extra_ok_ff    <= 1'b1;
         universe_ff    <= '0;
         opcode_lo_ff   <= '0;
      end else if (step) begin
         offset_ff      <= offset_in;
         lighting_ok_ff <= lighting_ok_in;
         stream_ok_ff   <= stream_ok_in;
         extra_ok_ff    <= extra_ok_in;
         universe_ff    <= universe_in;
         opcode_lo_ff   <= opcode_lo_in;
      end
   end

endmodule

// ----- sv/lighting_packet_to_dmx_slot_parser_top.sv -----
`timescale 1ns / 1ps
// udp payload to dmx slot parser for art-net and sacn. one payload byte is taken
// per item, with end_of_packet set on the final byte of each packet; a new item
// is accepted every cycle while the result side keeps up. each byte is held
// in an input register, then the header checks, universe capture and slot
// arithmetic run in one pass against the parser state, and any data byte of an
// accepted universe lands in the result register with its line and slot.
// throughput is one item per cycle while the result side keeps up, set by the
// single parse pass between the two registers. bytes that carry no slot
// (headers, trailing bytes, other universes) produce no result. the last slot
// of a frame is flagged frame_complete, so a short packet never completes.
module lighting_packet_to_dmx_slot_parser_top import dmxp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   // input register
   logic            in_valid_ff;
   req_payload_type in_data_ff;

   // result register
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;

   logic            step;
   logic            emit;
   rsp_payload_type result;
   dmxp_status_type status;

   // the held byte moves on once the result register is free or draining
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   dmxp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_data_ff),
      .emit    (emit),
      .result  (result),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (step && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // a packet end restarts the offset with both header flags fresh
   a_eop_restart: assert property (@(posedge clock) disable iff (reset)
      step && in_data_ff.end_of_packet |=>
         status.byte_offset == '0 && status.lighting_ok && status.stream_ok)
      else $error("parser state not cleared after end of packet");

   // no header byte has been judged at the start of a packet
   a_fresh_flags: assert property (@(posedge clock) disable iff (reset)
      status.byte_offset == '0 |-> status.lighting_ok && status.stream_ok)
      else $error("header flag cleared at packet start");

   // completion is only ever flagged on the final slot
   a_complete_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_complete |-> rsp_data.slot == LAST_SLOT)
      else $error("frame_complete on a slot other than the last");

   // a result still waiting blocks the parse pass
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !step)
      else $error("parse step while result register is held");

endmodule

// ----- bench/lighting_packet_to_dmx_slot_parser_top_tb.sv -----
`timescale 1ns / 1ps
module lighting_packet_to_dmx_slot_parser_top_tb;
   import dmxp_pkg::*;

   localparam int CLK_PERIOD = 20;
   localparam int RANDOM_ITEMS = 900;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 8;
   localparam int LAST_SCHEDULED = 3;
   // a full frame reaches the last slot, then a short tail past the data area is ignored
   localparam int ART_FULL_LEN = int'(ART_DATA_END);
   localparam int TAIL_LEN = 12;

   // identifiers, first character in the top byte
   localparam logic [55:0] ART_TAG = "Art-Net";
   localparam logic [31:0] SACN_TAG = "ASC-";

   typedef enum int {PKT_ARTNET, PKT_SACN, PKT_NOISE} pkt_kind_type;
   typedef enum int {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_mode_type;

   // one row of the directed script; typed rows carry a hand-written result
   typedef struct packed {
      req_payload_type item;
      bit              typed;
      bit              typed_hit;
      rsp_payload_type typed_rsp;
   } script_row_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   // parser state as seen by the bench
   logic [OFFSET_W-1:0] parse_offset;
   logic                art_hdr_ok;
   logic                sacn_hdr_ok;
   logic [15:0]         universe;
   logic                start_code_ok;
   logic [7:0]          opcode_lo;

   rsp_payload_type pending_slots [$];
   logic [7:0]      pkt_bytes [$];
   script_row_type  script [$];

   int  slot_errors = 0;
   int  items_sent = 0;
   int  burst_left = 0;
   int  stall_cycles = 0;
   bit  hold_off_req = 1'b0;

   lighting_packet_to_dmx_slot_parser_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic reset_parser();
      parse_offset = '0;
      art_hdr_ok = 1'b1;
      sacn_hdr_ok = 1'b1;
      universe = '0;
      start_code_ok = 1'b1;
      opcode_lo = '0;
   endtask

   // walks one payload byte through the header checks and works out its slot, if any
   task automatic parse_payload_byte(input req_payload_type it, output bit hit,
                                     output rsp_payload_type slot_res);
      logic [OFFSET_W-1:0] off;
      logic [OFFSET_W-1:0] slot_idx;
      logic [7:0]          b;
      int                  k;
      off = parse_offset;
      k = int'(off);
      b = it.payload_byte;
      hit = 1'b0;
      slot_idx = '0;
      slot_res = '0;

      // identifier compares, art-net at the very start, sacn a little further in
      if (off < ART_ID_LEN && b != ART_TAG[8*(6-k) +: 8])
         art_hdr_ok = 1'b0;
      if (off >= SACN_ID_FIRST && off <= SACN_ID_LAST && b != SACN_TAG[8*(7-k) +: 8])
         sacn_hdr_ok = 1'b0;

      // opcode is little-endian, so the low byte is held until the high one turns up
      if (off == ART_OPCODE_LO)
         opcode_lo = b;
      else if (off == ART_OPCODE_HI && {b, opcode_lo} != ART_OPDMX)
         art_hdr_ok = 1'b0;

      // a universe byte only counts while its own format is still alive
      if (art_hdr_ok) begin
         if (off == ART_UNIV_LO)
            universe[7:0] = b;
         else if (off == ART_UNIV_HI)
            universe[15:8] = b;
      end
      if (sacn_hdr_ok) begin
         if (off == SACN_UNIV_HI)
            universe[15:8] = b;
         else if (off == SACN_UNIV_LO)
            universe[7:0] = b;
         else if (off == SACN_START_CODE && b != 8'h00)
            start_code_ok = 1'b0;
      end

      if (art_hdr_ok && universe < UNIV_LIMIT && off >= ART_DATA_START &&
          {1'b0, off} < ART_DATA_END) begin
         hit = 1'b1;
         slot_idx = off - ART_DATA_START;
      end else if (sacn_hdr_ok && start_code_ok && universe < UNIV_LIMIT &&
                   off >= SACN_DATA_START && {1'b0, off} < SACN_DATA_END) begin
         hit = 1'b1;
         slot_idx = off - SACN_DATA_START;
      end
      if (hit) begin
         slot_res.line = universe[1:0];
         slot_res.slot = slot_idx[8:0];
         slot_res.level = b;
         slot_res.frame_complete = (slot_idx[8:0] == LAST_SLOT);
      end

      // end of packet puts everything back, otherwise the offset creeps up and sticks at the top
      if (it.end_of_packet)
         reset_parser();
      else if (parse_offset != OFFSET_MAX)
         parse_offset = parse_offset + OFFSET_W'(1);
   endtask

   function automatic script_row_type row(input logic [7:0] b, input bit eop, input bit typed,
                                          input bit hit, input rsp_payload_type r);
      script_row_type s;
      s.item.payload_byte = b;
      s.item.end_of_packet = eop;
      s.typed = typed;
      s.typed_hit = hit;
      s.typed_rsp = r;
      return s;
   endfunction

   // offers one item, in bursts with random gaps, and books its expected slot on acceptance
   task automatic send_byte(input req_payload_type it, input bit typed, input bit typed_hit,
                            input rsp_payload_type typed_rsp);
      int              gap;
      bit              hit;
      rsp_payload_type slot_res;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_data <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_payload_byte(it, hit, slot_res);
      if (typed) begin
         hit = typed_hit;
         slot_res = typed_rsp;
      end
      if (hit)
         pending_slots.push_back(slot_res);
      items_sent++;
      @(negedge clock);
   endtask

   // sender backs off until every booked slot has come out
   task automatic drain_pause();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_slots.size() != 0);
      burst_left = 0;
   endtask

   // one packet: the chosen kind's header (none for noise) over random bytes, garbled if corrupt
   task automatic build_packet(input pkt_kind_type kind, input int len, input logic [15:0] univ,
                               input bit corrupt);
      int i;
      int at;
      pkt_bytes.delete();
      for (i = 0; i < len; i++)
         pkt_bytes.push_back(8'($urandom));
      if (kind == PKT_ARTNET) begin
         for (i = 0; i < 7 && i < len; i++)
            pkt_bytes[i] = ART_TAG[8*(6-i) +: 8];
         if (len > ART_OPCODE_HI) begin
            pkt_bytes[ART_OPCODE_LO] = ART_OPDMX[7:0];
            pkt_bytes[ART_OPCODE_HI] = ART_OPDMX[15:8];
         end
         if (len > ART_UNIV_HI) begin
            pkt_bytes[ART_UNIV_LO] = univ[7:0];
            pkt_bytes[ART_UNIV_HI] = univ[15:8];
         end
      end else if (kind == PKT_SACN) begin
         // now and then the art-net prefix too, so both headers start out alive
         if (len > 3 && $urandom_range(0, 3) == 0)
            for (i = 0; i < 4; i++)
               pkt_bytes[i] = ART_TAG[8*(6-i) +: 8];
         for (i = 4; i < 8 && i < len; i++)
            pkt_bytes[i] = SACN_TAG[8*(7-i) +: 8];
         if (len > SACN_UNIV_LO) begin
            pkt_bytes[SACN_UNIV_HI] = univ[15:8];
            pkt_bytes[SACN_UNIV_LO] = univ[7:0];
         end
         if (len > SACN_START_CODE)
            pkt_bytes[SACN_START_CODE] = ($urandom_range(0, 6) == 0) ?
                                         8'($urandom_range(1, 255)) : 8'h00;
      end
      if (corrupt) begin
         if (kind == PKT_ARTNET)
            at = $urandom_range(0, 9);
         else
            at = ($urandom_range(0, 1) == 0) ? $urandom_range(4, 7) : int'(SACN_START_CODE);
         if (at < len)
            pkt_bytes[at] = 8'($urandom);
      end
   endtask

   task automatic check_slot(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_slots.size() == 0) begin
         slot_errors++;
         if (slot_errors <= MAX_REPORTS)
            $display("unexpected slot: line %0d slot %0d level %02h complete %0b",
                     got.line, got.slot, got.level, got.frame_complete);
      end else begin
         want = pending_slots.pop_front();
         if (got.line !== want.line || got.slot !== want.slot ||
             got.level !== want.level || got.frame_complete !== want.frame_complete) begin
            slot_errors++;
            if (slot_errors <= MAX_REPORTS)
               $display("slot mismatch: expected line %0d slot %0d level %02h complete %0b, %s",
                        want.line, want.slot, want.level, want.frame_complete,
                        $sformatf("got line %0d slot %0d level %02h complete %0b",
                                  got.line, got.slot, got.level, got.frame_complete));
         end
      end
   endtask

   // result side: compare every result taken, and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_slot(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("lighting_packet_to_dmx_slot_parser_top: mismatch");
            $finish;
         end
      end
   end

   // receiver: runs of open, choppy and starved cycles, plus one long hold-off on request
   initial begin : receiver
      int          run_left;
      rx_mode_type mode;
      run_left = 0;
      mode = RX_OPEN;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            if (run_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               run_left = $urandom_range(4, 40);
            end
            run_left--;
            case (mode)
               RX_OPEN: rsp_ready <= 1'b1;
               RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int           pkt_count;
      int           len;
      int           i;
      pkt_kind_type kind;
      bit           corrupt;
      logic [15:0]  univ;
      req_payload_type it;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      reset_parser();
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed script: lone bytes straight after reset, then a short art-net packet
      // on the top universe whose data bytes cover both level extremes and the midpoint
      script.push_back(row(8'h41, 1'b1, 1'b1, 1'b0, '0));
      script.push_back(row(8'h00, 1'b1, 1'b1, 1'b0, '0));
      script.push_back(row(8'h41, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h72, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h74, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h2D, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h4E, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h65, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h74, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h50, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'hFF, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h03, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h02, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'h00, 1'b0, 1'b0, 1'b0, '0));
      script.push_back(row(8'hFF, 1'b0, 1'b1, 1'b1, {2'd3, 9'd0, 8'hFF, 1'b0}));
      script.push_back(row(8'h00, 1'b0, 1'b1, 1'b1, {2'd3, 9'd1, 8'h00, 1'b0}));
      script.push_back(row(8'h80, 1'b1, 1'b1, 1'b1, {2'd3, 9'd2, 8'h80, 1'b0}));
      // fresh packet after the short one: a wrong first byte kills art-net at once
      script.push_back(row(8'hFF, 1'b1, 1'b1, 1'b0, '0));
      foreach (script[n])
         send_byte(script[n].item, script[n].typed, script[n].typed_hit, script[n].typed_rsp);

      // random packets, with two scheduled ones: a full art-net frame plus an ignored tail
      // under a long receiver hold-off, and a sacn packet after a drain
      pkt_count = 0;
      while (items_sent < RANDOM_ITEMS || pkt_count <= LAST_SCHEDULED) begin
         corrupt = 1'b0;
         case ($urandom_range(0, 9))
            0: univ = 16'($urandom);
            1: univ = 16'($urandom_range(4, 255));
            default: univ = 16'($urandom_range(0, 3));
         endcase
         case (pkt_count)
            1: begin
               kind = PKT_ARTNET;
               len = ART_FULL_LEN + TAIL_LEN;
               univ = 16'($urandom_range(0, 3));
               hold_off_req = 1'b1;
            end
            3: begin
               drain_pause();
               kind = PKT_SACN;
               len = $urandom_range(127, 190);
               univ = 16'($urandom_range(0, 3));
            end
            default: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: kind = PKT_ARTNET;
                  4, 5, 6, 7: kind = PKT_SACN;
                  default: kind = PKT_NOISE;
               endcase
               corrupt = ($urandom_range(0, 4) == 0);
               if (kind == PKT_ARTNET)
                  len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) :
                                                      $urandom_range(18, 90);
               else if (kind == PKT_SACN)
                  len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 126) :
                                                      $urandom_range(127, 190);
               else
                  len = $urandom_range(1, 24);
               if ($urandom_range(0, 11) == 0)
                  drain_pause();
            end
         endcase
         build_packet(kind, len, univ, corrupt);
         for (i = 0; i < len; i++) begin
            it.payload_byte = pkt_bytes[i];
            it.end_of_packet = (i == len - 1);
            send_byte(it, 1'b0, 1'b0, '0);
         end
         pkt_count++;
      end

      // let the last slots out, then a short tail to catch strays
      drain_pause();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (slot_errors == 0)
         $display("lighting_packet_to_dmx_slot_parser_top: match");
      else
         $display("lighting_packet_to_dmx_slot_parser_top: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/dmxp_pkg.sv
sv/dmxp_parser.sv
sv/lighting_packet_to_dmx_slot_parser_top.sv
bench/lighting_packet_to_dmx_slot_parser_top_tb.sv
